FILE: sv/cshash_pkg.sv
// ----------------------------------------------------------------------------
// cshash_pkg
// Shared types, constants and helper functions for the case-folding string
// hash block.
// ----------------------------------------------------------------------------
package cshash_pkg;

   localparam logic [31:0] DEFAULT_SEED = 32'h7FED_7FED;
   localparam logic [31:0] SHIFT_INIT   = 32'hEEEE_EEEE;

   // Depth of the queue between the front and back stages
   localparam int unsigned QUEUE_DEPTH = 2;

   // Configuration register map (index = word address)
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_START_SEED = 1'b0;
   localparam logic        REG_KEEP_CASE  = 1'b1;

   // Work item handed from front to back
   typedef struct packed {
      logic        start;   // first item of a string
      logic        last;    // last item of a string
      logic        empty;   // item carries no byte
      logic [7:0]  code;    // byte, folded unless case is kept
      logic [31:0] diff;    // tab[hi nibble] - tab[lo nibble]
   } entry_type;

   function automatic logic [31:0] nibble_word(input logic [3:0] idx);
      logic [31:0] w;
      case (idx)
         4'h0:    w = 32'h486E_26EE;
         4'h1:    w = 32'hDCAA_16B3;
         4'h2:    w = 32'hE191_8EEF;
         4'h3:    w = 32'h202D_AFDB;
         4'h4:    w = 32'h341C_7DC7;
         4'h5:    w = 32'h1C36_5303;
         4'h6:    w = 32'h40EF_2D37;
         4'h7:    w = 32'h65FD_5E49;
         4'h8:    w = 32'hD605_7177;
         4'h9:    w = 32'h904E_CE93;
         4'hA:    w = 32'h1C38_024F;
         4'hB:    w = 32'h98FD_323B;
         4'hC:    w = 32'hE306_1AE7;
         4'hD:    w = 32'hA39B_0FA1;
         4'hE:    w = 32'h9797_F25F;
         default: w = 32'hE444_4563;
      endcase
      return w;
   endfunction

   // Slash to backslash, lower case to upper case; everything else as is
   function automatic logic [7:0] fold_byte(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b == 8'h2F) begin
         r = 8'h5C;
      end else if (b >= 8'h61 && b <= 8'h7A) begin
         r = b - 8'h20;
      end
      return r;
   endfunction

endpackage

FILE: sv/case_folding_string_hash.sv
// ----------------------------------------------------------------------------
// case_folding_string_hash
// Case-folding string hash, one byte per transfer, with an APB register port.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue has room. The front stage folds the
// byte and looks up the nibble words, a two-entry queue follows, and the back
// stage does the hash and shift update; the result register holds the final
// hash, written when the last item of its string leaves the queue. Back pressure
// on the result side stalls only the last item of the next string; bytes keep
// flowing into the queue meanwhile, until it is full.
module case_folding_string_hash #(
   parameter int unsigned QUEUE_DEPTH = cshash_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] char_byte
   input  logic                              req_tlast,   // end_of_string
   input  logic                              req_tuser,   // [0] no_char
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // [31:0] hash_value
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cshash_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic                  start_seed_ff, keep_case_ff;
   logic [31:0]           seed_ff, seed_in;
   logic                  keep_in;
   logic                  csr_wr;
   logic                  reg_sel;
   cshash_pkg::entry_type fe_entry;
   cshash_pkg::entry_type q_entry;
   logic                  q_valid, q_ready;

   // ---- registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      seed_in = seed_ff;
      keep_in = keep_case_ff;
      if (csr_wr) begin
         case (reg_sel)
            cshash_pkg::REG_START_SEED: seed_in = csr_pwdata;
            cshash_pkg::REG_KEEP_CASE:  keep_in = csr_pwdata[0];
            default:                    seed_in = seed_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         cshash_pkg::REG_START_SEED: csr_prdata = seed_ff;
         cshash_pkg::REG_KEEP_CASE:  csr_prdata = {31'd0, keep_case_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= '0;
         keep_case_ff  <= 1'b0;
         start_seed_ff <= 1'b0;
      end else begin
         seed_ff       <= seed_in;
         keep_case_ff  <= keep_in;
         start_seed_ff <= (seed_in != '0);
      end
   end

   // ---- datapath
   cshash_front u_front (
      .clock         (clock),
      .reset         (reset),
      .keep_case     (keep_case_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .char_byte     (req_tdata),
      .end_of_string (req_tlast),
      .no_char       (req_tuser),
      .entry         (fe_entry)
   );

   cshash_queue #(
      .WIDTH ($bits(cshash_pkg::entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_data  (fe_entry),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_entry)
   );

   // Zero seed is mapped to the default inside the back stage
   cshash_back u_back (
      .clock      (clock),
      .reset      (reset),
      .start_seed (start_seed_ff ? seed_ff : 32'd0),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_hash   (rsp_tdata)
   );

endmodule

FILE: sv/cshash_front.sv
// ----------------------------------------------------------------------------
// cshash_front
// Accepts input items, folds the byte unless case is kept, looks up both nibble
// words and marks the start of each string before the item enters the queue.
// ----------------------------------------------------------------------------
module cshash_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  keep_case,
   input  logic                  in_valid,
   input  logic                  in_ready,
   input  logic [7:0]            char_byte,
   input  logic                  end_of_string,
   input  logic                  no_char,
   output cshash_pkg::entry_type entry
);

   logic       at_start_ff;
   logic       at_start_in;
   logic [7:0] code;

   assign at_start_in = (in_valid && in_ready) ? end_of_string : at_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else begin
         at_start_ff <= at_start_in;
      end
   end

   assign code = keep_case ? char_byte : cshash_pkg::fold_byte(char_byte);

   always_comb begin
      entry.start = at_start_ff;
      entry.last  = end_of_string;
      entry.empty = no_char;
      entry.code  = code;
      entry.diff  = cshash_pkg::nibble_word(code[7:4]) - cshash_pkg::nibble_word(code[3:0]);
   end

endmodule

FILE: sv/cshash_queue.sv
// ----------------------------------------------------------------------------
// cshash_queue
// Small register queue that decouples the front and back stages.
// ----------------------------------------------------------------------------
module cshash_queue #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = cshash_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: sv/cshash_back.sv
// ----------------------------------------------------------------------------
// cshash_back
// Runs the hash and shift recurrence on queued items and holds the final
// hash in an output register until it is taken.
// ----------------------------------------------------------------------------
module cshash_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [31:0]           start_seed,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  cshash_pkg::entry_type q_entry,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [31:0]           out_hash
);

   logic [31:0] hash_ff, hash_in;
   logic [31:0] shift_ff, shift_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_hash_ff, out_hash_in;
   logic [31:0] hash_cur, shift_cur, seed;
   logic [31:0] hash_new;
   logic        pop;

   // A last item needs the output register free (or freeing this cycle)
   assign q_ready = !q_entry.last || !out_valid_ff || out_ready;
   assign pop     = q_valid && q_ready;

   assign seed      = (start_seed != '0) ? start_seed : cshash_pkg::DEFAULT_SEED;
   assign hash_cur  = q_entry.start ? seed : hash_ff;
   assign shift_cur = q_entry.start ? cshash_pkg::SHIFT_INIT : shift_ff;
   assign hash_new  = q_entry.diff ^ (shift_cur + hash_cur);

   always_comb begin
      hash_in      = hash_ff;
      shift_in     = shift_ff;
      out_valid_in = out_ready ? 1'b0 : out_valid_ff;
      out_hash_in  = out_hash_ff;
      if (pop) begin
         if (q_entry.empty) begin
            hash_in  = hash_cur;
            shift_in = shift_cur;
         end else begin
            hash_in  = hash_new;
            // 33 * shift as shift * 32 + shift
            shift_in = {24'd0, q_entry.code} + hash_new + {shift_cur[26:0], 5'd0}
                       + shift_cur + 32'd3;
         end
         if (q_entry.last) begin
            out_valid_in = 1'b1;
            out_hash_in  = (hash_in != '0) ? hash_in : 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         shift_ff     <= cshash_pkg::SHIFT_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         shift_ff     <= shift_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_hash_ff <= out_hash_in;
   end

   assign out_valid = out_valid_ff;
   assign out_hash  = out_hash_ff;

endmodule

FILE: test/cshash_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cshash_checker
// Watches the byte stream, the hash stream and the register port of the
// case-folding string hash. It keeps its own copy of the registers and of the
// running hash, predicts the hash of every finished string, and compares each
// result transfer and each register read against that prediction.
// ----------------------------------------------------------------------------
module cshash_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] char_byte
   input  logic                              req_tlast,   // end_of_string
   input  logic                              req_tuser,   // [0] no_char
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [31:0]                       rsp_tdata,   // [31:0] hash_value
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cshash_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic [31:0]                       csr_prdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                hashes_pending
);

   localparam logic [31:0] SEED_FALLBACK = 32'h7FED_7FED;
   localparam logic [31:0] SHIFT_START   = 32'hEEEE_EEEE;
   localparam logic [cshash_pkg::CSR_ADDR_W-1:0] SEED_ADDR =
      {cshash_pkg::REG_START_SEED, 2'b00};
   localparam logic [cshash_pkg::CSR_ADDR_W-1:0] KEEP_ADDR =
      {cshash_pkg::REG_KEEP_CASE, 2'b00};

   logic [31:0] seed_reg;
   logic        keep_reg;
   logic [31:0] run_hash;
   logic [31:0] run_shift;
   logic        at_start;
   logic [31:0] expected_hashes [$];

   function automatic logic [31:0] mix_word(input logic [3:0] n);
      case (n)
         4'h0: return 32'h486E_26EE;
         4'h1: return 32'hDCAA_16B3;
         4'h2: return 32'hE191_8EEF;
         4'h3: return 32'h202D_AFDB;
         4'h4: return 32'h341C_7DC7;
         4'h5: return 32'h1C36_5303;
         4'h6: return 32'h40EF_2D37;
         4'h7: return 32'h65FD_5E49;
         4'h8: return 32'hD605_7177;
         4'h9: return 32'h904E_CE93;
         4'hA: return 32'h1C38_024F;
         4'hB: return 32'h98FD_323B;
         4'hC: return 32'hE306_1AE7;
         4'hD: return 32'hA39B_0FA1;
         4'hE: return 32'h9797_F25F;
         default: return 32'hE444_4563;
      endcase
   endfunction

   function automatic logic [7:0] fold_char(input logic [7:0] c);
      if (c == 8'h2F) return 8'h5C;
      if (c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
      return c;
   endfunction

   // Advances the running hash by one accepted item; queues the hash at end of string
   task automatic absorb_char(input logic [7:0] c_in, input logic last, input logic no_char);
      logic [7:0] c;
      c = keep_reg ? c_in : fold_char(c_in);
      if (at_start) begin
         run_hash  = (seed_reg != 32'd0) ? seed_reg : SEED_FALLBACK;
         run_shift = SHIFT_START;
         at_start  = 1'b0;
      end
      if (!no_char) begin
         run_hash  = (mix_word(c[7:4]) - mix_word(c[3:0])) ^ (run_shift + run_hash);
         run_shift = {24'd0, c} + run_hash + 32'd33 * run_shift + 32'd3;
      end
      if (last) begin
         expected_hashes.push_back((run_hash != 32'd0) ? run_hash : 32'd1);
         at_start = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         seed_reg  = 32'd0;
         keep_reg  = 1'b0;
         run_hash  = 32'd0;
         run_shift = SHIFT_START;
         at_start  = 1'b1;
         expected_hashes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == SEED_ADDR) seed_reg = csr_pwdata;
               else if (csr_paddr == KEEP_ADDR) keep_reg = csr_pwdata[0];
            end else begin
               want = (csr_paddr == SEED_ADDR) ? seed_reg : {31'd0, keep_reg};
               if (csr_prdata !== want) begin
                  $display("%0t: register read mismatch at %h: expected %h actual %h",
                           $time, csr_paddr, want, csr_prdata);
                  fail_count++;
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hashes.size() == 0) begin
               $display("%0t: hash transfer with none expected: expected none actual %h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_hashes.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: hash_value mismatch: expected %h actual %h",
                           $time, want, rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            absorb_char(req_tdata, req_tlast, req_tuser);
      end
      hashes_pending = expected_hashes.size();
   end

endmodule

FILE: test/tb_case_folding_string_hash.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_case_folding_string_hash
// Stimulus for the case-folding string hash: directed corner strings, then
// random strings under several seed and case settings, with random stalls on
// both streams and one long result-side hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_case_folding_string_hash;

   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD  = 300;
   localparam logic [cshash_pkg::CSR_ADDR_W-1:0] SEED_ADDR =
      {cshash_pkg::REG_START_SEED, 2'b00};
   localparam logic [cshash_pkg::CSR_ADDR_W-1:0] KEEP_ADDR =
      {cshash_pkg::REG_KEEP_CASE, 2'b00};

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata = 8'd0;   // [7:0] char_byte
   logic                              req_tlast = 1'b0;   // end_of_string
   logic                              req_tuser = 1'b0;   // [0] no_char
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [31:0]                       rsp_tdata;          // [31:0] hash_value
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [cshash_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                       csr_pwdata = 32'd0;
   logic [31:0]                       csr_prdata;
   logic                              csr_pready;

   int fail_count;
   int hashes_pending;
   int items_sent = 0;
   int idle_cycles = 0;
   int hold_requests = 0;
   int holds_done = 0;
   bit calm = 1'b0;   // no random idling on either side while set; a requested hold still applies

   always #10 clock = ~clock;

   case_folding_string_hash DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   cshash_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .fail_count(fail_count), .hashes_pending(hashes_pending)
   );

   // Watchdog: cycles without any transfer on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_case_folding_string_hash: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stalls, occasional long ones, and the requested hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            holds_done++;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 75);
         end
      end
   end

   function automatic int sender_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return 8'($urandom_range(0, 255));
      if (r < 62) return 8'($urandom_range(8'h61, 8'h7A));
      if (r < 72) return 8'($urandom_range(8'h41, 8'h5A));
      if (r < 80) return 8'h2F;
      if (r < 85) return 8'h5C;
      if (r < 90) return 8'h00;
      case ($urandom_range(0, 7))
         0: return 8'h60;
         1: return 8'h7B;
         2: return 8'h40;
         3: return 8'h5B;
         4: return 8'h7F;
         5: return 8'h80;
         6: return 8'hFF;
         default: return 8'h2E;
      endcase
   endfunction

   // One transfer on the byte stream; tvalid stays high until the next call or a settle
   task automatic send_item(input logic [7:0] c, input logic last, input logic no_char);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      req_tuser  <= no_char;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Sender stops and waits until every hash has come back, plus pipeline drain
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (hashes_pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [cshash_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [31:0] data);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr  <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] seed, input logic keep);
      csr_access(1'b1, SEED_ADDR, seed);
      csr_access(1'b1, KEEP_ADDR, {31'd0, keep});
      csr_access(1'b0, SEED_ADDR, 32'd0);
      csr_access(1'b0, KEEP_ADDR, 32'd0);
   endtask

   task automatic send_random_string();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 10) len = 0;
      else if (r < 75) len = $urandom_range(1, 6);
      else if (r < 95) len = $urandom_range(7, 20);
      else len = $urandom_range(21, 60);
      if (len == 0) begin
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end else begin
         // some strings end with a byte-less terminator instead of a last byte
         r = $urandom_range(0, 99);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 5)
               send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_item(pick_char(), (i == len - 1) && (r >= 15), 1'b0);
         end
         if (r < 15) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
   endtask

   task automatic run_phase(input logic [31:0] seed, input logic keep, input int n_items,
                            input bit quiet);
      int target;
      set_config(seed, keep);
      calm = quiet;
      target = items_sent + n_items;
      while (items_sent < target) send_random_string();
      calm = 1'b0;
      settle();
   endtask

   initial begin
      logic [7:0] corner_chars [8];
      int target;
      corner_chars = '{8'h2F, 8'h61, 8'h7A, 8'h60, 8'h7B, 8'h00, 8'h80, 8'hFF};
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // reset settings: zero seed falls back to the default, folding on
      send_item(8'hA5, 1'b1, 1'b1);
      foreach (corner_chars[i]) send_item(corner_chars[i], i == 7, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h41, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      settle();
      // all-ones seed, case kept
      set_config(32'hFFFF_FFFF, 1'b1);
      foreach (corner_chars[i]) send_item(corner_chars[i], i == 7, 1'b0);
      send_item(8'h5A, 1'b1, 1'b1);
      settle();

      // long result hold while the sender keeps pushing
      set_config($urandom(), 1'b0);
      calm = 1'b1;
      hold_requests++;
      target = items_sent + 60;
      while (items_sent < target) send_random_string();
      calm = 1'b0;
      settle();

      run_phase(32'd0, 1'b0, 120, 1'b0);
      run_phase(32'd0, 1'b1, 120, 1'b0);
      run_phase(32'hFFFF_FFFF, 1'b0, 120, 1'b1);
      run_phase(32'hFFFF_FFFF, 1'b1, 120, 1'b0);
      run_phase(32'd1, 1'b0, 120, 1'b0);
      run_phase(32'h8000_0000, 1'b1, 120, 1'b0);
      run_phase($urandom(), 1'($urandom_range(0, 1)), 120, 1'b0);
      run_phase($urandom(), 1'($urandom_range(0, 1)), 120, 1'b0);

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_case_folding_string_hash: PASS");
      end else begin
         $display("tb_case_folding_string_hash: FAIL");
      end
      $finish;
   end

endmodule
